[rtl/g3h_pkg.sv]
// Shared widths, types, codes and reset values of the 3D grid heuristic core.
package g3h_pkg;

    // Field and arithmetic widths
    localparam int COORD_BITS     = 10;
    localparam int COST_FRAC_BITS = 8;
    localparam int COST_BITS      = 16;
    localparam int DIST_BITS      = 28;
    localparam int CFG_IDX_BITS   = 2;
    localparam int CFG_DATA_BITS  = 16;

    // Sum of three differences, sum of three squares, padded to whole bit pairs
    localparam int DSUM_BITS = COORD_BITS + 2;
    localparam int SQ1_BITS  = 2 * COORD_BITS;
    localparam int SQ_BITS   = 2 * COORD_BITS + 2;
    localparam int SQ_PAD    = 2 * ((SQ_BITS + 1) / 2);

    // Square root: one cell per result bit
    localparam int ROOT_BITS = SQ_PAD / 2 + COST_FRAC_BITS;
    localparam int REM_BITS  = ROOT_BITS + 2;

    // Linear operand of the final multiply: the root or a difference sum
    localparam int OP_BITS = (ROOT_BITS > DSUM_BITS) ? ROOT_BITS : DSUM_BITS;

    // sqrt(3) in unsigned Q1.14
    localparam int SQRT3_BITS = 15;
    localparam int SQRT3_FRAC = 14;
    localparam int S3C_BITS   = COST_BITS + SQRT3_BITS;

    // Product and accumulator widths
    localparam int P1_BITS  = S3C_BITS + COORD_BITS;
    localparam int P2_BITS  = COST_BITS + COORD_BITS;
    localparam int P3_BITS  = COST_BITS + OP_BITS;
    localparam int ACC_BITS = P3_BITS + 2;

    typedef logic [COORD_BITS-1:0]    t_coord;
    typedef logic [DSUM_BITS-1:0]     t_dsum;
    typedef logic [SQ1_BITS-1:0]      t_sq1;
    typedef logic [SQ_BITS-1:0]       t_sq;
    typedef logic [SQ_PAD-1:0]        t_sqpad;
    typedef logic [ROOT_BITS-1:0]     t_root;
    typedef logic [REM_BITS-1:0]      t_rem;
    typedef logic [OP_BITS-1:0]       t_op;
    typedef logic [COST_BITS-1:0]     t_cost;
    typedef logic [SQRT3_BITS-1:0]    t_sqrt3;
    typedef logic [S3C_BITS-1:0]      t_s3c;
    typedef logic [P1_BITS-1:0]       t_p1;
    typedef logic [P2_BITS-1:0]       t_p2;
    typedef logic [P3_BITS-1:0]       t_p3;
    typedef logic [ACC_BITS-1:0]      t_acc;
    typedef logic [DIST_BITS-1:0]     t_dist;
    typedef logic [CFG_IDX_BITS-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_BITS-1:0] t_cfg_data;

    typedef enum logic [1:0] {
        METRIC_MANHATTAN = 2'd0,
        METRIC_CHEBYSHEV = 2'd1,
        METRIC_EUCLIDEAN = 2'd2,
        METRIC_DIAGONAL  = 2'd3
    } t_metric;

    // Register indexes on the configuration channel
    localparam t_cfg_idx REG_METRIC_MODE   = t_cfg_idx'(0);
    localparam t_cfg_idx REG_STRAIGHT_COST = t_cfg_idx'(1);
    localparam t_cfg_idx REG_FACE_COST     = t_cfg_idx'(2);

    // Constants and reset values
    localparam t_sqrt3  SQRT3_Q14      = t_sqrt3'(28378);
    localparam t_metric METRIC_RESET   = METRIC_MANHATTAN;
    localparam t_cost   STRAIGHT_RESET = t_cost'(256);
    localparam t_cost   FACE_RESET     = t_cost'(362);
    localparam t_s3c    S3C_RESET      = t_s3c'(STRAIGHT_RESET) * t_s3c'(SQRT3_Q14);
    localparam t_dist   DIST_MAX       = {DIST_BITS{1'b1}};

    // Operands for the cost stage that ride along the root chain
    typedef struct packed {
        t_coord low;   // smallest difference
        t_coord step;  // middle minus smallest
        t_op    lin;   // sum, maximum or largest minus middle, by metric
    } t_carry;

    // State handed from one root cell to the next
    typedef struct packed {
        t_sqpad bits;  // radicand, consumed two bits per cell from the top
        t_root  root;
        t_rem   rem;
        t_carry carry;
    } t_root_state;

endpackage

[rtl/g3h_channels_if.sv]
// Handshake channels of the heuristic core: cell pairs, distances, register writes.
interface g3h_req_if;
    logic                   valid;
    logic                   ready;
    g3h_pkg::t_coord        start_row;
    g3h_pkg::t_coord        start_col;
    g3h_pkg::t_coord        start_level;
    g3h_pkg::t_coord        goal_row;
    g3h_pkg::t_coord        goal_col;
    g3h_pkg::t_coord        goal_level;

    modport source (
        output valid, start_row, start_col, start_level, goal_row, goal_col, goal_level,
        input  ready
    );
    modport sink (
        input  valid, start_row, start_col, start_level, goal_row, goal_col, goal_level,
        output ready
    );
endinterface

interface g3h_rsp_if;
    logic                   valid;
    logic                   ready;
    g3h_pkg::t_dist         distance;

    modport source (output valid, distance, input ready);
    modport sink   (input valid, distance, output ready);
endinterface

interface g3h_cfg_if;
    logic                   valid;
    logic                   ready;
    g3h_pkg::t_cfg_idx      index;
    g3h_pkg::t_cfg_data     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/g3h_front.sv]
// Front end: absolute differences, sorting, metric operands and sum of squares.
module g3h_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  g3h_pkg::t_metric      i_mode,
    input  g3h_pkg::t_coord       i_start_row,
    input  g3h_pkg::t_coord       i_start_col,
    input  g3h_pkg::t_coord       i_start_level,
    input  g3h_pkg::t_coord       i_goal_row,
    input  g3h_pkg::t_coord       i_goal_col,
    input  g3h_pkg::t_coord       i_goal_level,
    output logic                  o_valid,
    output g3h_pkg::t_root_state  o_state
);

    // Stage 1 registers: differences
    logic                 r_v1;
    g3h_pkg::t_coord      r_dr, r_dc, r_dl;
    // Stage 2 registers: squares and operands
    logic                 r_v2;
    g3h_pkg::t_sq1        r_sq_r, r_sq_c, r_sq_l;
    g3h_pkg::t_carry      r_carry2;
    // Stage 3 registers: chain entry
    logic                 r_v3;
    g3h_pkg::t_root_state r_state3;

    g3h_pkg::t_coord      n_dr, n_dc, n_dl;
    g3h_pkg::t_coord      w_min, w_max, w_mid, w_lo1, w_hi1;
    g3h_pkg::t_dsum       w_sum;
    g3h_pkg::t_carry      n_carry2;
    g3h_pkg::t_root_state n_state3;

    // Absolute differences
    always_comb begin
        n_dr = (i_start_row   > i_goal_row)   ? i_start_row - i_goal_row
                                              : i_goal_row - i_start_row;
        n_dc = (i_start_col   > i_goal_col)   ? i_start_col - i_goal_col
                                              : i_goal_col - i_start_col;
        n_dl = (i_start_level > i_goal_level) ? i_start_level - i_goal_level
                                              : i_goal_level - i_start_level;
    end

    // Sort three differences and pick the linear operand of the metric
    always_comb begin
        w_lo1 = (r_dr < r_dc) ? r_dr : r_dc;
        w_hi1 = (r_dr < r_dc) ? r_dc : r_dr;
        w_min = (w_lo1 < r_dl) ? w_lo1 : r_dl;
        w_max = (w_hi1 > r_dl) ? w_hi1 : r_dl;
        w_sum = g3h_pkg::t_dsum'(r_dr) + g3h_pkg::t_dsum'(r_dc) + g3h_pkg::t_dsum'(r_dl);
        w_mid = g3h_pkg::t_coord'(w_sum - g3h_pkg::t_dsum'(w_min) - g3h_pkg::t_dsum'(w_max));
        n_carry2.low  = w_min;
        n_carry2.step = w_mid - w_min;
        case (i_mode)
            g3h_pkg::METRIC_MANHATTAN: n_carry2.lin = g3h_pkg::t_op'(w_sum);
            g3h_pkg::METRIC_CHEBYSHEV: n_carry2.lin = g3h_pkg::t_op'(w_max);
            g3h_pkg::METRIC_DIAGONAL:  n_carry2.lin = g3h_pkg::t_op'(w_max - w_mid);
            default:                   n_carry2.lin = '0;
        endcase
    end

    // Sum of squares enters the root chain with an empty root and remainder
    always_comb begin
        n_state3.bits  = g3h_pkg::t_sqpad'(g3h_pkg::t_sq'(r_sq_r) + g3h_pkg::t_sq'(r_sq_c)
                                           + g3h_pkg::t_sq'(r_sq_l));
        n_state3.root  = '0;
        n_state3.rem   = '0;
        n_state3.carry = r_carry2;
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dr     <= n_dr;
            r_dc     <= n_dc;
            r_dl     <= n_dl;
            r_sq_r   <= g3h_pkg::t_sq1'(r_dr) * g3h_pkg::t_sq1'(r_dr);
            r_sq_c   <= g3h_pkg::t_sq1'(r_dc) * g3h_pkg::t_sq1'(r_dc);
            r_sq_l   <= g3h_pkg::t_sq1'(r_dl) * g3h_pkg::t_sq1'(r_dl);
            r_carry2 <= n_carry2;
            r_state3 <= n_state3;
        end
    end

    assign o_valid = r_v3;
    assign o_state = r_state3;

endmodule

[rtl/g3h_root_cell.sv]
// One cell of the square root chain: settles one root bit and passes the state on.
module g3h_root_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  g3h_pkg::t_root_state  i_state,
    output logic                  o_valid,
    output g3h_pkg::t_root_state  o_state
);

    logic                             r_valid;
    g3h_pkg::t_root_state             r_state;
    g3h_pkg::t_root_state             n_state;
    logic [g3h_pkg::REM_BITS+1:0]     w_trial;
    logic [g3h_pkg::REM_BITS+1:0]     w_sub;
    logic [g3h_pkg::REM_BITS+1:0]     w_diff;

    // Bring down the next bit pair and try the subtraction
    always_comb begin
        w_trial = {i_state.rem, i_state.bits[g3h_pkg::SQ_PAD-1 -: 2]};
        w_sub   = {2'b00, i_state.root, 2'b01};
        w_diff  = w_trial - w_sub;
        n_state.bits  = {i_state.bits[g3h_pkg::SQ_PAD-3:0], 2'b00};
        n_state.carry = i_state.carry;
        if (w_trial >= w_sub) begin
            n_state.rem  = w_diff[g3h_pkg::REM_BITS-1:0];
            n_state.root = {i_state.root[g3h_pkg::ROOT_BITS-2:0], 1'b1};
        end else begin
            n_state.rem  = w_trial[g3h_pkg::REM_BITS-1:0];
            n_state.root = {i_state.root[g3h_pkg::ROOT_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_state <= n_state;
        end
    end

    assign o_valid = r_valid;
    assign o_state = r_state;

endmodule

[rtl/g3h_cost.sv]
// Cost stage: scales the metric operands by the step costs, sums and saturates.
module g3h_cost (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  g3h_pkg::t_root_state  i_state,
    input  g3h_pkg::t_metric      i_mode,
    input  g3h_pkg::t_cost        i_straight,
    input  g3h_pkg::t_cost        i_face,
    input  g3h_pkg::t_s3c         i_s3_cost,
    output logic                  o_valid,
    output g3h_pkg::t_dist        o_dist
);

    logic              r_v1, r_v2;
    g3h_pkg::t_p1      r_p1;
    g3h_pkg::t_p2      r_p2;
    g3h_pkg::t_p3      r_p3;
    g3h_pkg::t_dist    r_dist;

    g3h_pkg::t_op      w_op;
    g3h_pkg::t_acc     w_t1, w_t2, w_t3, w_acc;
    g3h_pkg::t_dist    n_dist;

    // Euclidean scales the root, the other metrics their linear operand
    assign w_op = (i_mode == g3h_pkg::METRIC_EUCLIDEAN) ? g3h_pkg::t_op'(i_state.root)
                                                        : i_state.carry.lin;

    // Terms, sum and clamp to the output range
    always_comb begin
        w_t1 = g3h_pkg::t_acc'(r_p1 >> g3h_pkg::SQRT3_FRAC);
        w_t2 = g3h_pkg::t_acc'(r_p2);
        if (i_mode == g3h_pkg::METRIC_EUCLIDEAN) begin
            w_t3 = g3h_pkg::t_acc'(r_p3 >> g3h_pkg::COST_FRAC_BITS);
        end else begin
            w_t3 = g3h_pkg::t_acc'(r_p3);
        end
        if (i_mode == g3h_pkg::METRIC_DIAGONAL) begin
            w_acc = w_t1 + w_t2 + w_t3;
        end else begin
            w_acc = w_t3;
        end
        if (w_acc > g3h_pkg::t_acc'(g3h_pkg::DIST_MAX)) begin
            n_dist = g3h_pkg::DIST_MAX;
        end else begin
            n_dist = g3h_pkg::t_dist'(w_acc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    // Three independent multipliers, then the adder stage
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1   <= g3h_pkg::t_p1'(i_s3_cost) * g3h_pkg::t_p1'(i_state.carry.low);
            r_p2   <= g3h_pkg::t_p2'(i_face) * g3h_pkg::t_p2'(i_state.carry.step);
            r_p3   <= g3h_pkg::t_p3'(i_straight) * g3h_pkg::t_p3'(w_op);
            r_dist <= n_dist;
        end
    end

    assign o_valid = r_v2;
    assign o_dist  = r_dist;

endmodule

[rtl/grid3d_heuristic_distance_core.sv]
// Top level of the 3D grid A* heuristic distance core.
//
//  channel  | dir | beat contents                              | accepted when
//  ---------+-----+--------------------------------------------+--------------
//  i_req    | in  | start_row/col/level, goal_row/col/level    | valid & ready
//  o_rsp    | out | distance (Q.8, saturated to 28 bits)       | valid & ready
//  i_cfg    | in  | index (0 mode, 1 straight, 2 face), data   | valid & ready
//
// One cell pair per cycle while the skid is free. Default widths give 3 front stages,
// one root cell per root bit (ROOT_BITS = 19), 2 cost stages and the output register.
// The root chain sets the depth; all metrics take the same path so beats stay in order.
// A beat stalled at o_rsp is backed by one skid register; ready drops only while it is
// full, and then the whole pipeline holds. Reset loads the register defaults and clears
// all valid bits; there is no clearing pass. i_cfg is always ready.
module grid3d_heuristic_distance_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    g3h_req_if.sink       i_req,
    g3h_rsp_if.source     o_rsp,
    g3h_cfg_if.sink       i_cfg
);

    // Configuration registers
    g3h_pkg::t_metric     r_mode;
    g3h_pkg::t_cost       r_straight;
    g3h_pkg::t_cost       r_face;
    g3h_pkg::t_s3c        r_s3_cost;

    // Output register and skid
    logic                 r_out_v, r_skid_v;
    g3h_pkg::t_dist       r_out_dist, r_skid_dist;
    logic                 n_out_v, n_skid_v;
    g3h_pkg::t_dist       n_out_dist, n_skid_dist;

    logic                 w_en;
    logic                 w_cost_v;
    g3h_pkg::t_dist       w_cost_dist;
    logic                 w_cell_v     [g3h_pkg::ROOT_BITS+1];
    g3h_pkg::t_root_state w_cell_state [g3h_pkg::ROOT_BITS+1];

    // Pipeline advances whenever the skid is free
    assign w_en        = !r_skid_v;
    assign i_req.ready = w_en;
    assign i_cfg.ready = 1'b1;

    // Register writes; straight cost times sqrt(3) is kept ready for the diagonal metric
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= g3h_pkg::METRIC_RESET;
            r_straight <= g3h_pkg::STRAIGHT_RESET;
            r_face     <= g3h_pkg::FACE_RESET;
            r_s3_cost  <= g3h_pkg::S3C_RESET;
        end else begin
            r_s3_cost <= g3h_pkg::t_s3c'(r_straight) * g3h_pkg::t_s3c'(g3h_pkg::SQRT3_Q14);
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    g3h_pkg::REG_METRIC_MODE:   r_mode     <= g3h_pkg::t_metric'(i_cfg.data[1:0]);
                    g3h_pkg::REG_STRAIGHT_COST: r_straight <= i_cfg.data[g3h_pkg::COST_BITS-1:0];
                    g3h_pkg::REG_FACE_COST:     r_face     <= i_cfg.data[g3h_pkg::COST_BITS-1:0];
                    default: ;
                endcase
            end
        end
    end

    g3h_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_en),
        .i_valid      (i_req.valid),
        .i_mode       (r_mode),
        .i_start_row  (i_req.start_row),
        .i_start_col  (i_req.start_col),
        .i_start_level(i_req.start_level),
        .i_goal_row   (i_req.goal_row),
        .i_goal_col   (i_req.goal_col),
        .i_goal_level (i_req.goal_level),
        .o_valid      (w_cell_v[0]),
        .o_state      (w_cell_state[0])
    );

    // Square root chain, one cell per root bit
    for (genvar g = 0; g < g3h_pkg::ROOT_BITS; g++) begin : g_cell
        g3h_root_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en),
            .i_valid(w_cell_v[g]),
            .i_state(w_cell_state[g]),
            .o_valid(w_cell_v[g+1]),
            .o_state(w_cell_state[g+1])
        );
    end

    g3h_cost u_cost (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (w_cell_v[g3h_pkg::ROOT_BITS]),
        .i_state   (w_cell_state[g3h_pkg::ROOT_BITS]),
        .i_mode    (r_mode),
        .i_straight(r_straight),
        .i_face    (r_face),
        .i_s3_cost (r_s3_cost),
        .o_valid   (w_cost_v),
        .o_dist    (w_cost_dist)
    );

    // Output register with skid: a finished beat lands in the output slot when it is
    // free or being taken, otherwise in the skid
    always_comb begin
        n_out_v     = r_out_v;
        n_out_dist  = r_out_dist;
        n_skid_v    = r_skid_v;
        n_skid_dist = r_skid_dist;
        if (!r_out_v || o_rsp.ready) begin
            if (r_skid_v) begin
                n_out_v    = 1'b1;
                n_out_dist = r_skid_dist;
                n_skid_v   = 1'b0;
            end else if (w_cost_v) begin
                n_out_v    = 1'b1;
                n_out_dist = w_cost_dist;
            end else begin
                n_out_v    = 1'b0;
            end
        end else if (w_en && w_cost_v) begin
            n_skid_v    = 1'b1;
            n_skid_dist = w_cost_dist;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_skid_v <= n_skid_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_dist  <= n_out_dist;
        r_skid_dist <= n_skid_dist;
    end

    assign o_rsp.valid    = r_out_v;
    assign o_rsp.distance = r_out_dist;

    // Skid only fills behind a held output beat
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid holds a beat while the output slot is empty");

    // A held skid beat is kept until the output beat is taken
    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && !o_rsp.ready) |=> (r_skid_v && $stable(r_skid_dist)))
        else $error("skid beat lost while output stalled");

    // Taking the output with a full skid moves the skid beat forward
    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && o_rsp.ready) |=>
            (r_out_v && !r_skid_v && r_out_dist == $past(r_skid_dist)))
        else $error("skid beat not forwarded to the output slot");

endmodule

[sim/testbench.sv]
// Self-checking testbench for the 3D grid heuristic distance core.
`timescale 1ns / 100ps

// One start/goal cell pair as seen on the request channel
typedef struct packed {
    g3h_pkg::t_coord start_row;
    g3h_pkg::t_coord start_col;
    g3h_pkg::t_coord start_level;
    g3h_pkg::t_coord goal_row;
    g3h_pkg::t_coord goal_col;
    g3h_pkg::t_coord goal_level;
} t_cell_pair;

// Register slot that the core must ignore
localparam g3h_pkg::t_cfg_idx REG_SPARE = g3h_pkg::t_cfg_idx'(3);

// Keeps a shadow of the registers and the queue of distances still owed
class distance_scoreboard;
    g3h_pkg::t_metric mode;
    g3h_pkg::t_cost   straight;
    g3h_pkg::t_cost   face;
    g3h_pkg::t_dist   pending[$];
    int unsigned      errors;

    function new();
        mode     = g3h_pkg::METRIC_RESET;
        straight = g3h_pkg::STRAIGHT_RESET;
        face     = g3h_pkg::FACE_RESET;
        errors   = 0;
    endfunction

    function void write_reg(g3h_pkg::t_cfg_idx idx, g3h_pkg::t_cfg_data data);
        case (idx)
            g3h_pkg::REG_METRIC_MODE:   mode = g3h_pkg::t_metric'(data[1:0]);
            g3h_pkg::REG_STRAIGHT_COST: straight = data;
            g3h_pkg::REG_FACE_COST:     face = data;
            default: ;
        endcase
    endfunction

    // Floor of the square root, digit by digit
    function longint unsigned floor_sqrt(longint unsigned x);
        longint unsigned r;
        longint unsigned probe;
        longint unsigned rem;
        r     = 0;
        rem   = x;
        probe = 64'd1 << 62;
        while (probe > rem)
            probe = probe >> 2;
        while (probe != 0) begin
            if (rem >= r + probe) begin
                rem = rem - (r + probe);
                r   = (r >> 1) + probe;
            end else begin
                r = r >> 1;
            end
            probe = probe >> 2;
        end
        return r;
    endfunction

    function g3h_pkg::t_dist heuristic(t_cell_pair p);
        longint unsigned dr, dc, dl, lo, mid, hi, t, acc, sc, fc;
        dr = (p.start_row > p.goal_row) ? p.start_row - p.goal_row
                                        : p.goal_row - p.start_row;
        dc = (p.start_col > p.goal_col) ? p.start_col - p.goal_col
                                        : p.goal_col - p.start_col;
        dl = (p.start_level > p.goal_level) ? p.start_level - p.goal_level
                                            : p.goal_level - p.start_level;
        sc = longint'(straight);
        fc = longint'(face);
        case (mode)
            g3h_pkg::METRIC_MANHATTAN: acc = sc * (dr + dc + dl);
            g3h_pkg::METRIC_CHEBYSHEV: begin
                t = dr;
                if (dc > t) t = dc;
                if (dl > t) t = dl;
                acc = sc * t;
            end
            g3h_pkg::METRIC_EUCLIDEAN: begin
                t   = floor_sqrt((dr * dr + dc * dc + dl * dl)
                                 << (2 * g3h_pkg::COST_FRAC_BITS));
                acc = (sc * t) >> g3h_pkg::COST_FRAC_BITS;
            end
            default: begin
                // sort the three differences, smallest first
                lo  = dr;
                mid = dc;
                hi  = dl;
                if (lo > mid) begin t = lo; lo = mid; mid = t; end
                if (mid > hi) begin t = mid; mid = hi; hi = t; end
                if (lo > mid) begin t = lo; lo = mid; mid = t; end
                acc = ((sc * longint'(g3h_pkg::SQRT3_Q14) * lo) >> g3h_pkg::SQRT3_FRAC)
                    + fc * (mid - lo) + sc * (hi - mid);
            end
        endcase
        if (acc > longint'(g3h_pkg::DIST_MAX))
            acc = longint'(g3h_pkg::DIST_MAX);
        return g3h_pkg::t_dist'(acc);
    endfunction

    function void note_pair(t_cell_pair p);
        pending.push_back(heuristic(p));
    endfunction

    function void check_distance(g3h_pkg::t_dist got);
        g3h_pkg::t_dist want;
        if (pending.size() == 0) begin
            $display("%0t: distance %0d arrived with no expected value", $time, got);
            errors++;
        end else begin
            want = pending.pop_front();
            if (got !== want) begin
                $display("%0t: distance mismatch, expected %0d, actual %0d",
                         $time, want, got);
                errors++;
            end
        end
    endfunction
endclass

module testbench;

    localparam int          HALF_PERIOD  = 10;
    localparam int          PIPE_LATENCY = 25;
    localparam int unsigned CYCLE_LIMIT  = 500000;
    localparam int          PHASES       = 16;
    localparam int          PHASE_ITEMS  = 110;
    localparam int          COORD_MAX    = (1 << g3h_pkg::COORD_BITS) - 1;
    localparam int          DIRECTED_N   = 7;

    logic i_clk;
    logic i_rst_n;

    g3h_req_if req_ch();
    g3h_rsp_if rsp_ch();
    g3h_cfg_if cfg_ch();

    grid3d_heuristic_distance_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    distance_scoreboard sb = new();

    int unsigned cycles    = 0;
    bit          quiet     = 0;
    int          tx_odds   = 0;
    int          rx_odds   = 0;
    int          rx_stall  = 0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #(HALF_PERIOD) i_clk = ~i_clk;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // Result sink: random stall bursts, none once the run goes quiet
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!quiet && rx_stall == 0 && rx_odds != 0 && $urandom_range(1, 16) <= rx_odds)
                rx_stall = $urandom_range(1, 11);
            rsp_ch.ready <= (rx_stall == 0);
            if (rx_stall > 0)
                rx_stall--;
        end
    end

    // Beat monitor: register writes, accepted pairs, returned distances
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready)
                sb.write_reg(cfg_ch.index, cfg_ch.data);
            if (req_ch.valid && req_ch.ready)
                sb.note_pair('{req_ch.start_row, req_ch.start_col, req_ch.start_level,
                               req_ch.goal_row, req_ch.goal_col, req_ch.goal_level});
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_distance(rsp_ch.distance);
        end
    end

    function automatic t_cell_pair make_pair(int sr, int sc, int sl, int gr, int gc, int gl);
        t_cell_pair p;
        p.start_row   = g3h_pkg::t_coord'(sr);
        p.start_col   = g3h_pkg::t_coord'(sc);
        p.start_level = g3h_pkg::t_coord'(sl);
        p.goal_row    = g3h_pkg::t_coord'(gr);
        p.goal_col    = g3h_pkg::t_coord'(gc);
        p.goal_level  = g3h_pkg::t_coord'(gl);
        return p;
    endfunction

    function automatic g3h_pkg::t_coord near_coord(g3h_pkg::t_coord s);
        int d;
        int v;
        d = $urandom_range(0, 16);
        v = int'(s) + d - 8;
        if (v < 0)
            v = 0;
        if (v > COORD_MAX)
            v = COORD_MAX;
        return g3h_pkg::t_coord'(v);
    endfunction

    function automatic g3h_pkg::t_coord corner_coord();
        return $urandom_range(0, 1) ? g3h_pkg::t_coord'(COORD_MAX) : g3h_pkg::t_coord'(0);
    endfunction

    // Mix of wide spans, close neighbors, grid corners and equal cells
    function automatic t_cell_pair random_pair();
        t_cell_pair p;
        int kind;
        kind          = $urandom_range(0, 9);
        p.start_row   = g3h_pkg::t_coord'($urandom_range(0, COORD_MAX));
        p.start_col   = g3h_pkg::t_coord'($urandom_range(0, COORD_MAX));
        p.start_level = g3h_pkg::t_coord'($urandom_range(0, COORD_MAX));
        p.goal_row    = g3h_pkg::t_coord'($urandom_range(0, COORD_MAX));
        p.goal_col    = g3h_pkg::t_coord'($urandom_range(0, COORD_MAX));
        p.goal_level  = g3h_pkg::t_coord'($urandom_range(0, COORD_MAX));
        if (kind == 6 || kind == 7) begin
            p.goal_row   = near_coord(p.start_row);
            p.goal_col   = near_coord(p.start_col);
            p.goal_level = near_coord(p.start_level);
        end else if (kind == 8) begin
            p.start_row   = corner_coord();
            p.start_col   = corner_coord();
            p.start_level = corner_coord();
            p.goal_row    = corner_coord();
            p.goal_col    = corner_coord();
            p.goal_level  = corner_coord();
        end else if (kind == 9) begin
            p.goal_row   = p.start_row;
            p.goal_col   = p.start_col;
            p.goal_level = p.start_level;
        end
        return p;
    endfunction

    // Present one pair, with an optional idle burst ahead of it
    task automatic send_pair(t_cell_pair p);
        int gap;
        gap = 0;
        if (!quiet && tx_odds != 0 && $urandom_range(1, 16) <= tx_odds)
            gap = $urandom_range(1, 11);
        if (gap > 0) begin
            @(negedge i_clk) req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        req_ch.valid       <= 1'b1;
        req_ch.start_row   <= p.start_row;
        req_ch.start_col   <= p.start_col;
        req_ch.start_level <= p.start_level;
        req_ch.goal_row    <= p.goal_row;
        req_ch.goal_col    <= p.goal_col;
        req_ch.goal_level  <= p.goal_level;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    // Stop sending and wait for every owed distance
    task automatic drain();
        @(negedge i_clk) req_ch.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_register(g3h_pkg::t_cfg_idx idx, g3h_pkg::t_cfg_data data);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk) cfg_ch.valid <= 1'b0;
    endtask

    // Full register setup; junk in the upper mode bits and a write to the spare slot
    task automatic configure(g3h_pkg::t_metric mode, g3h_pkg::t_cost straight,
                             g3h_pkg::t_cost face);
        set_register(REG_SPARE, g3h_pkg::t_cfg_data'($urandom));
        set_register(g3h_pkg::REG_METRIC_MODE,
                     (g3h_pkg::t_cfg_data'($urandom) & 16'hFFFC) | g3h_pkg::t_cfg_data'(mode));
        set_register(g3h_pkg::REG_STRAIGHT_COST, straight);
        set_register(g3h_pkg::REG_FACE_COST, face);
    endtask

    // Main sequence
    initial begin
        t_cell_pair     directed[DIRECTED_N];
        g3h_pkg::t_cost s_cost;
        g3h_pkg::t_cost f_cost;

        i_rst_n            = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.start_row   = '0;
        req_ch.start_col   = '0;
        req_ch.start_level = '0;
        req_ch.goal_row    = '0;
        req_ch.goal_col    = '0;
        req_ch.goal_level  = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = g3h_pkg::REG_METRIC_MODE;
        cfg_ch.data        = '0;

        // equal cells, full spans both ways, mixed and tied differences
        directed[0] = make_pair(0, 0, 0, 0, 0, 0);
        directed[1] = make_pair(1023, 1023, 1023, 1023, 1023, 1023);
        directed[2] = make_pair(0, 0, 0, 1023, 1023, 1023);
        directed[3] = make_pair(1023, 1023, 1023, 0, 0, 0);
        directed[4] = make_pair(1023, 0, 512, 0, 1023, 511);
        directed[5] = make_pair(100, 0, 0, 0, 50, 7);
        directed[6] = make_pair(3, 900, 20, 3, 1, 25);

        repeat (4) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // Directed pairs under each metric at default costs; manhattan straight from reset
        for (int m = 0; m < 4; m++) begin
            if (m != 0)
                configure(g3h_pkg::t_metric'(m), g3h_pkg::STRAIGHT_RESET,
                          g3h_pkg::FACE_RESET);
            foreach (directed[i])
                send_pair(directed[i]);
            drain();
        end

        // Random phases: cost extremes first, then random costs; quiet at the end
        for (int ph = 0; ph < PHASES; ph++) begin
            quiet   = (ph >= PHASES - 2);
            tx_odds = (ph % 3 == 0) ? 0 : $urandom_range(1, 6);
            rx_odds = (ph % 4 == 1) ? 0 : $urandom_range(1, 6);
            case (ph / 4)
                0: begin s_cost = 16'hFFFF; f_cost = 16'h0000; end
                1: begin s_cost = 16'h0000; f_cost = 16'hFFFF; end
                2: begin
                    s_cost = g3h_pkg::t_cost'($urandom_range(1, 1023));
                    f_cost = g3h_pkg::t_cost'($urandom_range(1, 1023));
                end
                default: begin
                    s_cost = g3h_pkg::t_cost'($urandom);
                    f_cost = g3h_pkg::t_cost'($urandom);
                end
            endcase
            configure(g3h_pkg::t_metric'(ph % 4), s_cost, f_cost);
            repeat (PHASE_ITEMS)
                send_pair(random_pair());
            drain();
        end

        repeat (2 * PIPE_LATENCY) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/g3h_pkg.sv
rtl/g3h_channels_if.sv
rtl/g3h_front.sv
rtl/g3h_root_cell.sv
rtl/g3h_cost.sv
rtl/grid3d_heuristic_distance_core.sv
sim/testbench.sv
